// File: rtl/swr_pkg.sv
// ----------------------------------------------------------------------------
// swr_pkg
// Shared constants, codes, item types and the byte-wise CRC-32 update for the
// stop-and-wait receiver.
// ----------------------------------------------------------------------------
package swr_pkg;

   localparam int MAX_PAYLOAD  = 512;
   localparam int CNT_W        = $clog2(MAX_PAYLOAD + 1);
   localparam int ID_W         = 32;
   localparam int CRC_W        = 32;
   localparam int SIZE_W       = 10;
   localparam int DATA_W       = 8;

   localparam logic [CRC_W-1:0] CRC_POLY     = 32'hEDB8_8320;
   localparam logic [CRC_W-1:0] CRC_SEED_RST = 32'hFFFF_FFFF;
   localparam logic [ID_W-1:0]  FIRST_ID_RST = 32'd1;

   typedef enum logic [1:0] {
      VERDICT_ACCEPT  = 2'd0,
      VERDICT_CRC_ERR = 2'd1,
      VERDICT_DUP     = 2'd2
   } verdict_type;

   typedef enum logic {
      CSR_CRC_SEED = 1'b0,
      CSR_FIRST_ID = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [DATA_W-1:0] data_byte;
      logic              last_byte;
      logic [ID_W-1:0]   packet_id;
      logic [SIZE_W-1:0] payload_size;
      logic [CRC_W-1:0]  carried_crc;
   } req_item_type;

   // reflected crc-32, one byte, no final xor
   function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                 input logic [DATA_W-1:0] b);
      logic [CRC_W-1:0] c;
      c = crc ^ {{(CRC_W-DATA_W){1'b0}}, b};
      for (int k = 0; k < DATA_W; k++) begin
         if (c[0]) begin
            c = CRC_POLY ^ (c >> 1);
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

// File: rtl/swr_req_if.sv
// ----------------------------------------------------------------------------
// swr_req_if
// Input channel: one payload byte per transfer with its packet header fields.
// ----------------------------------------------------------------------------
interface swr_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  data_byte;
   logic        last_byte;
   logic [31:0] packet_id;
   logic [9:0]  payload_size;
   logic [31:0] carried_crc;

   modport source (output valid, output data_byte, output last_byte, output packet_id,
                   output payload_size, output carried_crc, input ready);
   modport sink   (input valid, input data_byte, input last_byte, input packet_id,
                   input payload_size, input carried_crc, output ready);
endinterface

// File: rtl/swr_rsp_if.sv
// ----------------------------------------------------------------------------
// swr_rsp_if
// Result channel: one acknowledgment per transfer.
// ----------------------------------------------------------------------------
interface swr_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] ack_id;
   logic [9:0]  ack_size;
   logic        error_flag;
   logic [1:0]  verdict;
   logic [31:0] computed_crc;

   modport source (output valid, output ack_id, output ack_size, output error_flag,
                   output verdict, output computed_crc, input ready);
   modport sink   (input valid, input ack_id, input ack_size, input error_flag,
                   input verdict, input computed_crc, output ready);
endinterface

// File: rtl/swr_csr_if.sv
// ----------------------------------------------------------------------------
// swr_csr_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface swr_csr_if;
   logic        valid;
   logic        ready;
   logic        index;
   logic [31:0] wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

// File: rtl/stop_wait_receiver_crc32.sv
// ----------------------------------------------------------------------------
// stop_wait_receiver_crc32
// Stop-and-wait receiver with a running reflected CRC-32 check.
//
// req_ch carries one payload byte per transfer together with the packet id,
// declared size and carried CRC; last_byte marks the end of a packet.
// rsp_ch carries at most one acknowledgment per packet, issued for its last
// byte: accept (expected id advances), crc error (error_flag set) or
// duplicate for an older id. A newer id produces no transfer on rsp_ch.
// csr_ch writes crc_seed (index 0) and first_id (index 1, also reloads the
// expected id); it is always ready; the user must write it only while idle,
// and the block itself does not enforce this. Throughput is one byte per
// cycle while rsp_ch does not stall. The CRC update and id compare run
// between the input register and the result register that drives rsp_ch.
// When rsp_ch stalls with a result held, the input register fills and
// req_ch ready drops until the result is taken.
// Reset clears the pipeline, sets crc_seed to all ones and the expected id
// to 1, and drops any partial packet.
// ----------------------------------------------------------------------------
module stop_wait_receiver_crc32 (
   input  logic      clock,
   input  logic      reset,
   swr_req_if.sink   req_ch,
   swr_rsp_if.source rsp_ch,
   swr_csr_if.sink   csr_ch
);
   import swr_pkg::*;

   logic         take;
   logic         item_valid;
   req_item_type item;

   swr_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .take       (take),
      .item_valid (item_valid),
      .item       (item)
   );

   swr_check u_check (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .take       (take),
      .csr_ch     (csr_ch),
      .rsp_ch     (rsp_ch)
   );

endmodule

// File: rtl/swr_in_stage.sv
// ----------------------------------------------------------------------------
// swr_in_stage
// Input register: captures one byte transfer and holds it until the check
// stage takes it.
// ----------------------------------------------------------------------------
module swr_in_stage (
   input  logic                  clock,
   input  logic                  reset,
   swr_req_if.sink               req_ch,
   input  logic                  take,
   output logic                  item_valid,
   output swr_pkg::req_item_type item
);
   import swr_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;
   logic         req_xfer;

   assign req_ch.ready = !valid_ff || take;
   assign req_xfer     = req_ch.valid && req_ch.ready;

   always_comb begin
      valid_in = valid_ff;
      if (req_xfer) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         item_ff.data_byte    <= req_ch.data_byte;
         item_ff.last_byte    <= req_ch.last_byte;
         item_ff.packet_id    <= req_ch.packet_id;
         item_ff.payload_size <= req_ch.payload_size;
         item_ff.carried_crc  <= req_ch.carried_crc;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// File: rtl/swr_check.sv
// ----------------------------------------------------------------------------
// swr_check
// Running CRC, packet tracking, id check and result register, plus the
// configuration registers.
// ----------------------------------------------------------------------------
module swr_check (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  item_valid,
   input  swr_pkg::req_item_type item,
   output logic                  take,
   swr_csr_if.sink               csr_ch,
   swr_rsp_if.source             rsp_ch
);
   import swr_pkg::*;

   logic [CRC_W-1:0]  crc_seed_ff;
   logic [ID_W-1:0]   expected_id_ff, expected_id_in;
   logic [CRC_W-1:0]  running_crc_ff;
   logic              in_packet_ff;
   logic [CNT_W-1:0]  byte_cnt_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]   ack_id_ff;
   logic [SIZE_W-1:0] ack_size_ff;
   verdict_type       verdict_ff;
   logic [CRC_W-1:0]  computed_crc_ff;

   logic              advance;
   logic              csr_xfer;
   logic [CRC_W-1:0]  base_crc, new_crc;
   logic [CNT_W-1:0]  base_cnt, new_cnt;
   logic              id_match, id_old, crc_good, has_rsp;
   verdict_type       verdict_in;

   assign take     = !rsp_valid_ff || rsp_ch.ready;
   assign advance  = item_valid && take;
   assign csr_ch.ready = 1'b1;
   assign csr_xfer = csr_ch.valid && csr_ch.ready;

   always_comb begin
      base_crc = in_packet_ff ? running_crc_ff : crc_seed_ff;
      base_cnt = in_packet_ff ? byte_cnt_ff : '0;
      if (base_cnt < CNT_W'(MAX_PAYLOAD)) begin
         new_crc = crc_byte(base_crc, item.data_byte);
         new_cnt = base_cnt + CNT_W'(1);
      end else begin
         new_crc = base_crc;
         new_cnt = base_cnt;
      end
      id_match = (item.packet_id == expected_id_ff);
      id_old   = (item.packet_id < expected_id_ff);
      crc_good = (new_crc == item.carried_crc);
      has_rsp  = item.last_byte && (id_match || id_old);
      if (id_match) begin
         verdict_in = crc_good ? VERDICT_ACCEPT : VERDICT_CRC_ERR;
      end else begin
         verdict_in = VERDICT_DUP;
      end
   end

   always_comb begin
      expected_id_in = expected_id_ff;
      if (csr_xfer && csr_index_type'(csr_ch.index) == CSR_FIRST_ID) begin
         expected_id_in = csr_ch.wdata;
      end else if (advance && item.last_byte && id_match && crc_good) begin
         expected_id_in = expected_id_ff + ID_W'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = has_rsp;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_seed_ff    <= CRC_SEED_RST;
         expected_id_ff <= FIRST_ID_RST;
         in_packet_ff   <= 1'b0;
         byte_cnt_ff    <= '0;
         running_crc_ff <= CRC_SEED_RST;
         rsp_valid_ff   <= 1'b0;
      end else begin
         expected_id_ff <= expected_id_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_xfer && csr_index_type'(csr_ch.index) == CSR_CRC_SEED) begin
            crc_seed_ff <= csr_ch.wdata;
         end
         if (advance) begin
            in_packet_ff   <= !item.last_byte;
            byte_cnt_ff    <= item.last_byte ? '0 : new_cnt;
            running_crc_ff <= new_crc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ack_id_ff       <= item.packet_id;
         ack_size_ff     <= item.payload_size;
         verdict_ff      <= verdict_in;
         computed_crc_ff <= new_crc;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.ack_id       = ack_id_ff;
   assign rsp_ch.ack_size     = ack_size_ff;
   assign rsp_ch.verdict      = verdict_ff;
   assign rsp_ch.error_flag   = (verdict_ff == VERDICT_CRC_ERR);
   assign rsp_ch.computed_crc = computed_crc_ff;

   // good packet moves the expected id on by one
   assert property (@(posedge clock) disable iff (reset)
      (advance && item.last_byte && id_match && crc_good && !csr_xfer)
      |=> expected_id_ff == $past(expected_id_ff) + ID_W'(1))
      else $error("expected id did not advance");

   // last byte closes the packet
   assert property (@(posedge clock) disable iff (reset)
      (advance && item.last_byte) |=> !in_packet_ff && byte_cnt_ff == '0)
      else $error("packet not closed after last byte");

   // a held result is never overwritten
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ch.ready) |-> !advance)
      else $error("stage advanced into a stalled result");

   // count never passes the payload bound
   assert property (@(posedge clock) disable iff (reset)
      byte_cnt_ff <= CNT_W'(MAX_PAYLOAD))
      else $error("byte count out of range");

endmodule

// File: sim/stop_wait_receiver_crc32_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stop_wait_receiver_crc32_checker
// Watches the byte, acknowledgment and register channels of the receiver.
// Keeps its own copy of the crc and sequence state, queues the expected
// acknowledgments and compares every rsp transfer against the oldest one.
// ----------------------------------------------------------------------------
module stop_wait_receiver_crc32_checker (
   input  logic clock,
   input  logic reset,
   swr_req_if   req_ch,
   swr_rsp_if   rsp_ch,
   swr_csr_if   csr_ch,
   output int   error_count,
   output int   pending_acks
);
   import swr_pkg::*;

   typedef struct {
      logic [ID_W-1:0]   id;
      logic [SIZE_W-1:0] size;
      logic              err;
      verdict_type       verdict;
      logic [CRC_W-1:0]  crc;
   } ack_item_type;

   ack_item_type     ack_queue[$];
   logic [CRC_W-1:0] seed_reg;
   logic [ID_W-1:0]  next_id;
   logic [CRC_W-1:0] crc_acc;
   logic             mid_packet;
   int               bytes_taken;

   initial begin
      error_count  = 0;
      pending_acks = 0;
   end

   function automatic logic [CRC_W-1:0] crc32_shift_in(input logic [CRC_W-1:0] acc,
                                                       input logic [DATA_W-1:0] b);
      logic [CRC_W-1:0] r;
      logic             fb;
      r = acc;
      for (int i = 0; i < DATA_W; i++) begin
         fb = r[0] ^ b[i];
         r  = r >> 1;
         if (fb) begin
            r = r ^ CRC_POLY;
         end
      end
      return r;
   endfunction

   task automatic absorb_byte();
      logic [CRC_W-1:0] acc;
      ack_item_type     ack;
      if (!mid_packet) begin
         acc         = seed_reg;
         bytes_taken = 0;
      end else begin
         acc = crc_acc;
      end
      if (bytes_taken < MAX_PAYLOAD) begin
         acc = crc32_shift_in(acc, req_ch.data_byte);
         bytes_taken++;
      end
      if (!req_ch.last_byte) begin
         crc_acc    = acc;
         mid_packet = 1'b1;
      end else begin
         crc_acc     = seed_reg;
         mid_packet  = 1'b0;
         bytes_taken = 0;
         ack.id      = req_ch.packet_id;
         ack.size    = req_ch.payload_size;
         ack.crc     = acc;
         if (req_ch.packet_id == next_id) begin
            if (acc == req_ch.carried_crc) begin
               ack.verdict = VERDICT_ACCEPT;
               next_id     = next_id + 1'b1;
            end else begin
               ack.verdict = VERDICT_CRC_ERR;
            end
            ack.err = (ack.verdict == VERDICT_CRC_ERR);
            ack_queue.push_back(ack);
         end else if (req_ch.packet_id < next_id) begin
            ack.verdict = VERDICT_DUP;
            ack.err     = 1'b0;
            ack_queue.push_back(ack);
         end
      end
   endtask

   task automatic check_ack();
      ack_item_type want;
      if (ack_queue.size() == 0) begin
         if (error_count < 10) begin
            $display("%0t: unexpected ack transfer id=%h verdict=%0d", $realtime,
                     rsp_ch.ack_id, rsp_ch.verdict);
         end
         error_count++;
      end else begin
         want = ack_queue.pop_front();
         if (rsp_ch.ack_id !== want.id || rsp_ch.ack_size !== want.size ||
             rsp_ch.error_flag !== want.err || rsp_ch.verdict !== want.verdict ||
             rsp_ch.computed_crc !== want.crc) begin
            if (error_count < 10) begin
               $display("%0t: ack mismatch expected id=%h size=%0d err=%0d verdict=%0d crc=%h",
                        $realtime, want.id, want.size, want.err, want.verdict, want.crc);
               $display("%0t:                 got id=%h size=%0d err=%0d verdict=%0d crc=%h",
                        $realtime, rsp_ch.ack_id, rsp_ch.ack_size, rsp_ch.error_flag,
                        rsp_ch.verdict, rsp_ch.computed_crc);
            end
            error_count++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         seed_reg    = CRC_SEED_RST;
         next_id     = FIRST_ID_RST;
         crc_acc     = CRC_SEED_RST;
         mid_packet  = 1'b0;
         bytes_taken = 0;
         ack_queue.delete();
      end else begin
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_index_type'(csr_ch.index))
               CSR_CRC_SEED: begin
                  seed_reg = csr_ch.wdata;
               end
               CSR_FIRST_ID: begin
                  next_id = csr_ch.wdata;
               end
               default: ;
            endcase
         end
         if (req_ch.valid && req_ch.ready) begin
            absorb_byte();
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            check_ack();
         end
      end
      pending_acks <= ack_queue.size();
   end

endmodule

// File: sim/stop_wait_receiver_crc32_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stop_wait_receiver_crc32_tb
// Drives packets byte by byte into the receiver: a directed set covering
// accept, crc error, duplicate, newer id, seed and first id changes, then
// random packets over three register settings with varying back-pressure.
// ----------------------------------------------------------------------------
module stop_wait_receiver_crc32_tb;
   import swr_pkg::*;

   localparam int CYCLE_LIMIT = 300000;

   logic clock;
   logic reset;

   swr_req_if req_ch ();
   swr_rsp_if rsp_ch ();
   swr_csr_if csr_ch ();

   int               error_count;
   int               pending_acks;
   int               cycle_count = 0;
   int               send_idle;
   int               rsp_idle;
   int               items_sent = 0;
   int               phase;
   int               target;
   bit               overlong_done = 1'b0;
   logic [CRC_W-1:0] cur_seed;
   logic [ID_W-1:0]  stim_id;

   stop_wait_receiver_crc32 DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   stop_wait_receiver_crc32_checker ack_check (
      .clock        (clock),
      .reset        (reset),
      .req_ch       (req_ch),
      .rsp_ch       (rsp_ch),
      .csr_ch       (csr_ch),
      .error_count  (error_count),
      .pending_acks (pending_acks)
   );

   initial begin
      clock = 1'b0;
   end

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= rsp_idle);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("stop_wait_receiver_crc32_tb: errors");
         $finish;
      end
   end

   task automatic push_byte(input logic [7:0] d, input logic last, input logic [31:0] id,
                            input logic [9:0] size, input logic [31:0] crc);
      while ($urandom_range(99) < send_idle) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.data_byte    <= d;
      req_ch.last_byte    <= last;
      req_ch.packet_id    <= id;
      req_ch.payload_size <= size;
      req_ch.carried_crc  <= crc;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      items_sent++;
   endtask

   // stop sending until all acks are back and the pipeline has emptied
   task automatic wait_quiet();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_acks != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [31:0] v);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.wdata <= v;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
      csr_ch.valid <= 1'b0;
      if (idx == CSR_CRC_SEED) begin
         cur_seed = v;
      end else begin
         stim_id = v;
      end
      @(posedge clock);
   endtask

   task automatic send_packet(input int len, input logic [31:0] id, input logic [9:0] size,
                              input bit good, input bit noisy, input bit reseed_mid,
                              input int fill);
      logic [7:0]  payload[$];
      logic [7:0]  b;
      logic [31:0] acc;
      logic [31:0] carried;
      logic [31:0] flip;
      acc = cur_seed;
      for (int k = 0; k < len; k++) begin
         b = (fill < 0) ? 8'($urandom) : fill[7:0];
         payload.push_back(b);
         if (k < MAX_PAYLOAD) begin
            acc = crc_byte(acc, b);
         end
      end
      flip = $urandom;
      if (flip == '0) begin
         flip = 32'h1;
      end
      carried = good ? acc : acc ^ flip;
      for (int k = 0; k < len; k++) begin
         if (reseed_mid && k > 0 && k == len / 2) begin
            wait_quiet();
            write_csr(CSR_CRC_SEED, $urandom);
         end
         if (k == len - 1) begin
            push_byte(payload[k], 1'b1, id, size, carried);
         end else if (noisy) begin
            push_byte(payload[k], 1'b0, $urandom, 10'($urandom), $urandom);
         end else begin
            push_byte(payload[k], 1'b0, id, size, carried);
         end
      end
      if (id == stim_id && good) begin
         stim_id = stim_id + 1'b1;
      end
   endtask

   task automatic random_packet();
      int          len;
      int          pick;
      logic [31:0] id;
      logic [9:0]  size;
      pick = $urandom_range(99);
      if (!overlong_done && phase == 2) begin
         len           = $urandom_range(520, 513);
         overlong_done = 1'b1;
      end else if (pick < 10) begin
         len = $urandom_range(40, 9);
      end else begin
         len = $urandom_range(8, 1);
      end
      pick = $urandom_range(99);
      if (pick < 65 || (pick < 80 && stim_id == '0)) begin
         id = stim_id;
      end else if (pick < 80) begin
         id = (stim_id > 8) ? stim_id - $urandom_range(8, 1) : $urandom_range(stim_id - 1, 0);
      end else if (pick < 90) begin
         id = stim_id + $urandom_range(1000, 1);
      end else begin
         id = $urandom;
      end
      size = ($urandom_range(99) < 80) ? len[9:0] : 10'($urandom);
      if ($urandom_range(99) < 5) begin
         wait_quiet();
      end
      send_packet(len, id, size, $urandom_range(99) < 80, $urandom_range(99) < 10,
                  $urandom_range(99) < 2, -1);
   endtask

   initial begin
      send_idle           = 34;
      rsp_idle            = 58;
      cur_seed            = CRC_SEED_RST;
      stim_id             = FIRST_ID_RST;
      phase               = 0;
      reset               = 1'b1;
      req_ch.valid        = 1'b0;
      req_ch.data_byte    = '0;
      req_ch.last_byte    = 1'b0;
      req_ch.packet_id    = '0;
      req_ch.payload_size = '0;
      req_ch.carried_crc  = '0;
      rsp_ch.ready        = 1'b0;
      csr_ch.valid        = 1'b0;
      csr_ch.index        = CSR_CRC_SEED;
      csr_ch.wdata        = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed packets at reset settings
      send_packet(1, 32'd1, 10'd1, 1'b1, 1'b0, 1'b0, 8'h00);
      send_packet(3, 32'd2, 10'd3, 1'b0, 1'b0, 1'b0, 8'hFF);
      send_packet(2, 32'd2, 10'h3FF, 1'b1, 1'b0, 1'b0, -1);
      send_packet(1, 32'd1, 10'd0, 1'b1, 1'b0, 1'b0, -1);
      send_packet(1, 32'hFFFF_FFFF, 10'd0, 1'b1, 1'b0, 1'b0, -1);
      send_packet(1, 32'd0, 10'h200, 1'b0, 1'b0, 1'b0, -1);
      send_packet(3, stim_id, 10'd3, 1'b1, 1'b1, 1'b0, -1);
      wait_quiet();
      write_csr(CSR_CRC_SEED, 32'h0000_0000);
      send_packet(2, stim_id, 10'd2, 1'b1, 1'b0, 1'b0, -1);
      send_packet(4, stim_id, 10'd4, 1'b1, 1'b0, 1'b1, -1);
      wait_quiet();
      write_csr(CSR_FIRST_ID, 32'hFFFF_FFFF);
      send_packet(1, 32'hFFFF_FFFF, 10'd1, 1'b1, 1'b0, 1'b0, -1);
      send_packet(1, 32'd0, 10'd1, 1'b1, 1'b0, 1'b0, -1);
      send_packet(1, 32'd0, 10'd1, 1'b1, 1'b0, 1'b0, -1);

      for (phase = 0; phase < 3; phase++) begin
         wait_quiet();
         case (phase)
            0: begin
               send_idle = 34;
               rsp_idle  = 58;
               write_csr(CSR_CRC_SEED, $urandom);
               write_csr(CSR_FIRST_ID, 32'h0000_0000);
            end
            1: begin
               send_idle = 58;
               rsp_idle  = 34;
               write_csr(CSR_CRC_SEED, 32'h0000_0000);
               write_csr(CSR_FIRST_ID, $urandom);
            end
            default: begin
               send_idle = 0;
               rsp_idle  = 0;
               write_csr(CSR_CRC_SEED, 32'hFFFF_FFFF);
               write_csr(CSR_FIRST_ID, 32'hFFFF_FFFF);
            end
         endcase
         target = items_sent + 60;
         while (items_sent < target) begin
            random_packet();
         end
      end

      wait_quiet();
      if (error_count == 0) begin
         $display("stop_wait_receiver_crc32_tb: clean");
      end else begin
         $display("stop_wait_receiver_crc32_tb: errors");
      end
      $finish;
   end

endmodule
